FILE: src/completion_deadline_table_core_assert.svh
// assertion macros for the completion deadline table checker
// expects clk and arst_n in the scope of each use
`ifndef COMPLETION_DEADLINE_TABLE_CORE_ASSERT_SVH
`define COMPLETION_DEADLINE_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define CDT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("completion deadline table assertion failed");

// next-cycle implication
`define CDT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("completion deadline table assertion failed");

`endif

FILE: src/cdt_pkg.sv
// shared constants, codes and controller/datapath interface types
// for the completion deadline table; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cdt_pkg;

	localparam int SLOTS_DEF = 64;

	localparam int OP_W     = 3;
	localparam int TAG_W    = 32;
	localparam int STAT_W   = 2;
	localparam int PEND_W   = 7;
	localparam int LAT_W    = 32;
	localparam int TIME_W   = 64;
	localparam int CFG_IDX_W = 2;

	localparam int IN_W  = 40;
	localparam int OUT_W = 48;
	localparam int OUT_USED = STAT_W + TAG_W + PEND_W;

	localparam logic [OP_W-1:0] OP_READ  = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
	localparam logic [OP_W-1:0] OP_FLUSH = 3'd2;
	localparam logic [OP_W-1:0] OP_POLL  = 3'd3;
	localparam logic [OP_W-1:0] OP_DRAIN = 3'd4;
	localparam logic [OP_W-1:0] OP_TICK  = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_BUSY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_READ_LAT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_LAT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLUSH_LAT = 2'd2;

	localparam logic [LAT_W-1:0] READ_LAT_RST  = 32'd2200;
	localparam logic [LAT_W-1:0] WRITE_LAT_RST = 32'd33000;
	localparam logic [LAT_W-1:0] FLUSH_LAT_RST = 32'd0;

	localparam logic [PEND_W-1:0] PEND_MAX = 7'd127;

	typedef struct packed {
		logic capture;
		logic tick;
		logic sub_step;
		logic scan_issue;
		logic scan_eval;
		logic idx_inc;
		logic out_load;
	} cdt_cmd_t;

	typedef struct packed {
		logic kind_submit;
		logic kind_scan;
		logic kind_tick;
		logic sub_free;
		logic idx_last;
		logic poll_hit;
		logic out_free;
	} cdt_stat_t;

endpackage

`default_nettype wire

FILE: src/cdt_ctrl.sv
// controller state machine for the completion deadline table
// depends on cdt_pkg for the command and status types
`timescale 1ns / 1ps
`default_nettype none

module cdt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire cdt_pkg::cdt_stat_t stat,
	output cdt_pkg::cdt_cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SUBMIT = 5'b00010,
		S_SCAN   = 5'b00100,
		S_TAIL   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (stat.kind_submit) begin
						state_d = S_SUBMIT;
					end else if (stat.kind_scan) begin
						state_d = S_SCAN;
					end else begin
						cmd.tick = stat.kind_tick;
						state_d  = S_FINISH;
					end
				end
			end
			S_SUBMIT: begin
				cmd.sub_step = 1'b1;
				if (stat.sub_free || stat.idx_last) begin
					state_d = S_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_eval = 1'b1;
				if (stat.poll_hit) begin
					state_d = S_FINISH;
				end else begin
					cmd.scan_issue = 1'b1;
					if (stat.idx_last) begin
						state_d = S_TAIL;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			S_TAIL: begin
				cmd.scan_eval = 1'b1;
				state_d       = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: src/cdt_dpath.sv
// datapath: slot busy bits, deadline and tag memories, time counter,
// latency registers, result and output registers; depends on cdt_pkg
`timescale 1ns / 1ps
`default_nettype none

module cdt_dpath #(
	parameter int SLOTS = cdt_pkg::SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [cdt_pkg::IN_W-1:0]      in_data,
	input  wire logic                          cfg_valid,
	input  wire logic [cdt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cdt_pkg::LAT_W-1:0]     cfg_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [cdt_pkg::OUT_W-1:0]          out_data,
	input  wire cdt_pkg::cdt_cmd_t             cmd,
	output cdt_pkg::cdt_stat_t                 stat
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
	localparam int OUT_PAD = cdt_pkg::OUT_W - cdt_pkg::OUT_USED;

	logic [cdt_pkg::OP_W-1:0]   in_op;
	logic [cdt_pkg::TAG_W-1:0]  in_tag;

	logic [cdt_pkg::OP_W-1:0]   op_q;
	logic [cdt_pkg::TAG_W-1:0]  tag_q;
	logic [cdt_pkg::LAT_W-1:0]  read_lat_q, write_lat_q, flush_lat_q;
	logic [cdt_pkg::TIME_W-1:0] time_q;
	logic [IDX_W-1:0]           idx_q;
	logic [SLOTS-1:0]           busy_q;

	logic [cdt_pkg::TIME_W-1:0] dl_mem  [SLOTS];
	logic [cdt_pkg::TAG_W-1:0]  tag_mem [SLOTS];

	logic                       v_s1;
	logic                       busy_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic [cdt_pkg::TIME_W-1:0] dl_s1;
	logic [cdt_pkg::TAG_W-1:0]  tag_s1;

	logic [cdt_pkg::STAT_W-1:0] res_status_q;
	logic [cdt_pkg::TAG_W-1:0]  res_tag_q;
	logic [cdt_pkg::PEND_W-1:0] res_pend_q;

	logic                       out_valid_q;
	logic [cdt_pkg::OUT_W-1:0]  out_data_q;

	logic [cdt_pkg::LAT_W-1:0]  lat_sel;
	logic [cdt_pkg::TIME_W-1:0] deadline;
	logic                       sub_free;
	logic                       expired_s1;
	logic                       op_is_poll;
	logic                       op_is_drain;
	logic                       out_free;

	assign in_op  = in_data[cdt_pkg::OP_W-1:0];
	assign in_tag = in_data[cdt_pkg::OP_W +: cdt_pkg::TAG_W];

	assign op_is_poll  = (op_q == cdt_pkg::OP_POLL);
	assign op_is_drain = (op_q == cdt_pkg::OP_DRAIN);

	always_comb begin
		case (op_q)
			cdt_pkg::OP_READ:  lat_sel = read_lat_q;
			cdt_pkg::OP_WRITE: lat_sel = write_lat_q;
			default:           lat_sel = flush_lat_q;
		endcase
	end

	assign deadline   = time_q + {{(cdt_pkg::TIME_W - cdt_pkg::LAT_W){1'b0}}, lat_sel};
	assign sub_free   = !busy_q[idx_q];
	assign expired_s1 = v_s1 && busy_s1 && (time_q >= dl_s1);
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		stat             = '0;
		stat.kind_submit = (in_op == cdt_pkg::OP_READ) || (in_op == cdt_pkg::OP_WRITE)
		                   || (in_op == cdt_pkg::OP_FLUSH);
		stat.kind_scan   = (in_op == cdt_pkg::OP_POLL) || (in_op == cdt_pkg::OP_DRAIN);
		stat.kind_tick   = (in_op == cdt_pkg::OP_TICK);
		stat.sub_free    = sub_free;
		stat.idx_last    = (idx_q == IDX_LAST);
		stat.poll_hit    = expired_s1 && op_is_poll;
		stat.out_free    = out_free;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_lat_q  <= cdt_pkg::READ_LAT_RST;
			write_lat_q <= cdt_pkg::WRITE_LAT_RST;
			flush_lat_q <= cdt_pkg::FLUSH_LAT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				cdt_pkg::REG_READ_LAT:  read_lat_q  <= cfg_data;
				cdt_pkg::REG_WRITE_LAT: write_lat_q <= cfg_data;
				cdt_pkg::REG_FLUSH_LAT: flush_lat_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// control state: time, index, busy bits, scan valid, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q      <= '0;
			idx_q       <= '0;
			busy_q      <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.tick) begin
				time_q <= time_q + 64'd1;
			end
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.sub_step && sub_free) begin
				busy_q[idx_q] <= 1'b1;
			end
			if (cmd.scan_eval && expired_s1) begin
				busy_q[idx_s1] <= 1'b0;
			end
			v_s1 <= cmd.scan_issue;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture and result accumulation
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= in_op;
			tag_q     <= in_tag;
			res_tag_q <= '0;
			res_pend_q <= '0;
			if (stat.kind_scan) begin
				res_status_q <= cdt_pkg::ST_BUSY;
			end else begin
				res_status_q <= cdt_pkg::ST_OK;
			end
		end
		if (cmd.sub_step && !sub_free && (idx_q == IDX_LAST)) begin
			res_status_q <= cdt_pkg::ST_FULL;
		end
		if (cmd.scan_eval && v_s1) begin
			if (expired_s1) begin
				res_status_q <= cdt_pkg::ST_OK;
				if (op_is_poll) begin
					res_tag_q <= tag_s1;
				end
			end else if (busy_s1 && op_is_drain && (res_pend_q != cdt_pkg::PEND_MAX)) begin
				res_pend_q <= res_pend_q + 7'd1;
			end
		end
		if (cmd.out_load) begin
			out_data_q <= {{OUT_PAD{1'b0}}, res_pend_q, res_tag_q, res_status_q};
		end
	end

	// deadline and tag memories
	always_ff @(posedge clk) begin
		if (cmd.sub_step && sub_free) begin
			dl_mem[idx_q] <= deadline;
			tag_mem[idx_q] <= (op_q == cdt_pkg::OP_FLUSH) ? tag_q : '0;
		end
		if (cmd.scan_issue) begin
			dl_s1   <= dl_mem[idx_q];
			tag_s1  <= tag_mem[idx_q];
			busy_s1 <= busy_q[idx_q];
			idx_s1  <= idx_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

FILE: src/completion_deadline_table_core.sv
// top level of the completion deadline table: controller plus datapath
// depends on cdt_pkg, cdt_ctrl and cdt_dpath
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    s_tdata: op, tag_in
// m_*      out  m_tvalid/m_tready    m_tdata: status, tag_out, pending_count
// cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one request at a time; slots are visited one per cycle through the deadline and tag memories
// submit: slots are searched from index 0 up to the lowest free one; status is FULL when none is free
// poll: stops at the first expired slot; drain or a poll with nothing expired visits every slot
// tick and unused codes: no slot is visited; tick advances the time counter
// reset clears busy bits and time at once, no clearing pass; cfg_ready is always high
// a waiting result is held in the output register while the next request is taken
`timescale 1ns / 1ps
`default_nettype none

module completion_deadline_table_core #(
	parameter int SLOTS = cdt_pkg::SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [cdt_pkg::IN_W-1:0]      s_tdata,   // op[2:0], tag_in[34:3]
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [cdt_pkg::OUT_W-1:0]          m_tdata,   // status[1:0], tag_out[33:2], pending_count[40:34]
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [cdt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cdt_pkg::LAT_W-1:0]     cfg_data
);

	cdt_pkg::cdt_cmd_t  cmd;
	cdt_pkg::cdt_stat_t stat;

	assign cfg_ready = 1'b1;

	cdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cdt_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire

FILE: src/cdt_checker.sv
// port-level checks for the completion deadline table, bound to the top level
// depends on cdt_pkg and completion_deadline_table_core_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "completion_deadline_table_core_assert.svh"

module cdt_checker (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     s_tvalid,
	input wire logic                     s_tready,
	input wire logic                     m_tvalid,
	input wire logic                     m_tready,
	input wire logic [cdt_pkg::OUT_W-1:0] m_tdata
);

	`CDT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`CDT_ASSERT_IMP(a_full_clean, m_tvalid && (m_tdata[1:0] == cdt_pkg::ST_FULL), m_tdata[40:2] == '0)
	`CDT_ASSERT_IMP(a_busy_no_tag, m_tvalid && (m_tdata[1:0] == cdt_pkg::ST_BUSY), m_tdata[33:2] == '0)
	`CDT_ASSERT_NXT(a_one_request, s_tvalid && s_tready, !s_tready)

endmodule

bind completion_deadline_table_core cdt_checker u_cdt_checker (.*);

`default_nettype wire
